FILE: design/fasa_pkg.sv
// fasa_pkg: shared types and constants of the frame aged slot allocator
// used by fasa_pick and frame_aged_slot_allocator, depends on nothing
`timescale 1ns / 1ps

package fasa_pkg;

  // default pool geometry
  localparam int DEF_SLOTS     = 1024;
  localparam int DEF_MAP_WORDS = 32;

  // register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 1'b1;
  localparam logic [15:0] BASE_RESET = 16'd2048;

  // position store reset pattern (largest finite float)
  localparam logic [31:0] POS_RESET = 32'h7F7F_FFFF;

  // map word layout: bit 31 is the lowest slot of a word
  localparam logic [31:0] MAP_MSB = 32'h8000_0000;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_ALLOC   = 2'd1,
    ST_EXHAUST = 2'd2,
    ST_FRAME   = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FRAME,
    S_EMIT
  } state_t;

  // result of the shared map word unit
  typedef struct packed {
    logic        found;
    logic [4:0]  lz;
    logic [31:0] cur_word;
  } pick_t;

endpackage

FILE: design/fasa_ram.sv
// fasa_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fasa_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fasa_pick.sv
// fasa_pick: shared map word unit, ands the three age maps and finds the
// lowest free slot of the word (most significant set bit); uses fasa_pkg
`timescale 1ns / 1ps

module fasa_pick (
  input  logic [3:0][31:0]   words,
  input  logic [1:0]         phase,
  output fasa_pkg::pick_t    res
);
  import fasa_pkg::*;

  logic [31:0] cur_w;
  logic [31:0] prv_w;
  logic [31:0] ppv_w;
  logic [31:0] avail;

  // select current, previous and previous-previous map by frame phase
  assign cur_w = words[phase];
  assign prv_w = words[phase - 2'd1];
  assign ppv_w = words[phase - 2'd2];
  assign avail = cur_w & prv_w & ppv_w;

  // leading one search, highest set bit wins
  always_comb begin
    res.found    = |avail;
    res.lz       = '0;
    res.cur_word = cur_w;
    for (int i = 0; i < 32; i++) begin
      if (avail[i]) begin
        res.lz = 5'(31 - i);
      end
    end
  end

endmodule

FILE: design/frame_aged_slot_allocator.sv
// frame_aged_slot_allocator: top level, sequencer, map and position stores
// depends on fasa_pkg, fasa_ram, fasa_pick
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_ready   | req_type, cached_handle, pos_x/y/z
//   out     | out       | out_valid / out_ready | handle_out, status
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// after reset a clearing pass over max(SLOTS, MAP_WORDS) addresses fills the stores
// a cache hit goes from accept through ram read, compare and emit back to idle
// an allocation reads and checks each map word visited by the rover in turn,
// after the lookup when a cached handle missed; one shared pick unit checks a word
// a frame advance rewrites every word of the new current map
// in_ready is high only while idle; a result waits in the output register
`timescale 1ns / 1ps

module frame_aged_slot_allocator #(
  parameter int SLOTS     = fasa_pkg::DEF_SLOTS,
  parameter int MAP_WORDS = fasa_pkg::DEF_MAP_WORDS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   req_type,
  input  logic [15:0]                            cached_handle,
  input  logic [31:0]                            pos_x,
  input  logic [31:0]                            pos_y,
  input  logic [31:0]                            pos_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [15:0]                            handle_out,
  output fasa_pkg::status_t                      status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fasa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fasa_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import fasa_pkg::*;

  localparam int WORD_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CLR_LEN = (SLOTS > MAP_WORDS) ? SLOTS : MAP_WORDS;
  localparam int CLR_W   = $clog2(CLR_LEN);

  // control registers
  state_t              state;
  state_t              state_next;
  logic [CLR_W-1:0]    clr_cnt;
  logic [1:0]          phase;
  logic                failed;
  logic [WORD_W-1:0]   rover;
  logic                cache_en;
  logic [15:0]         base;

  // payload registers
  logic [15:0]         lat_handle;
  logic [31:0]         lat_x;
  logic [31:0]         lat_y;
  logic [31:0]         lat_z;
  logic [SLOT_AW-1:0]  lat_slot;
  logic [WORD_W-1:0]   lat_word;
  logic                lat_word_ok;
  logic [4:0]          lat_bit;
  logic [WORD_W-1:0]   scan_w;
  logic [15:0]         res_handle;
  status_t             res_status;

  // store ports
  logic [3:0]          map_we;
  logic [WORD_W-1:0]   map_waddr;
  logic [31:0]         map_wdata;
  logic [WORD_W-1:0]   map_raddr;
  logic [3:0][31:0]    map_rdata;
  logic                pos_we;
  logic [SLOT_AW-1:0]  pos_waddr;
  logic [95:0]         pos_wdata;
  logic [SLOT_AW-1:0]  pos_raddr;
  logic [95:0]         pos_rdata;

  // datapath nets
  pick_t               pick;
  logic [17:0]         hit_d;
  logic                cand;
  logic                pos_match;
  logic [WORD_W-1:0]   w_next;
  logic                w_wrap;
  logic [13:0]         gslot;
  logic                gslot_ok;
  logic [15:0]         grant_handle;
  logic [4:0]          clr_bit;
  logic                res_ok;
  logic                in_beat;
  logic                cfg_beat;

  // four age maps, read together at one word address
  for (genvar g = 0; g < 4; g++) begin : g_map
    fasa_ram #(.W(32), .D(MAP_WORDS)) u_map (
      .clk   (clk),
      .we    (map_we[g]),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata[g])
    );
  end

  // stored positions, x in the upper word
  fasa_ram #(.W(96), .D(SLOTS)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // shared and / leading one unit
  fasa_pick u_pick (
    .words (map_rdata),
    .phase (phase),
    .res   (pick)
  );

  // cached handle decode: slot = handle - 1 - base, borrow means miss
  assign hit_d = 18'(cached_handle) - 18'(base) - 18'd1;
  assign cand  = (cached_handle != 16'd0) && cache_en && !hit_d[17] &&
                 (hit_d[16:0] < 17'(SLOTS));

  assign pos_match = (pos_rdata == {lat_x, lat_y, lat_z});

  // rover step with wrap
  assign w_wrap = (scan_w == WORD_W'(MAP_WORDS - 1));
  assign w_next = w_wrap ? '0 : scan_w + WORD_W'(1);

  // granted slot and handle
  assign gslot        = 14'({scan_w, pick.lz});
  assign gslot_ok     = (gslot < 14'(SLOTS));
  assign grant_handle = 16'(gslot) + base + 16'd1;

  assign clr_bit  = (state == S_LOOK_CMP) ? lat_bit : pick.lz;
  assign res_ok   = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_beat = cfg_valid && cfg_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == CLR_W'(CLR_LEN - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (req_type)    state_next = S_FRAME;
          else if (cand)   state_next = S_LOOK_RD;
          else if (failed) state_next = S_EMIT;
          else             state_next = S_SCAN_RD;
        end
      end
      S_LOOK_RD: state_next = S_LOOK_CMP;
      S_LOOK_CMP: begin
        if (pos_match || failed) state_next = S_EMIT;
        else                     state_next = S_SCAN_RD;
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (pick.found || (w_next == rover)) state_next = S_EMIT;
        else                                 state_next = S_SCAN_RD;
      end
      S_FRAME: begin
        if (w_wrap) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (res_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // store controls and handshake
  always_comb begin
    in_ready  = 1'b0;
    map_we    = '0;
    map_waddr = scan_w;
    map_wdata = '1;
    map_raddr = scan_w;
    pos_we    = 1'b0;
    pos_waddr = gslot[SLOT_AW-1:0];
    pos_wdata = {lat_x, lat_y, lat_z};
    pos_raddr = lat_slot;
    unique case (state)
      S_CLEAR: begin
        map_we    = '1;
        map_waddr = clr_cnt[WORD_W-1:0];
        pos_we    = 1'b1;
        pos_waddr = clr_cnt[SLOT_AW-1:0];
        pos_wdata = {POS_RESET, POS_RESET, POS_RESET};
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_LOOK_RD: begin
        map_raddr = lat_word;
      end
      S_LOOK_CMP: begin
        map_waddr = lat_word;
        map_wdata = pick.cur_word & ~(MAP_MSB >> clr_bit);
        if (pos_match && lat_word_ok) map_we[phase] = 1'b1;
      end
      S_SCAN_RD: begin
        map_raddr = scan_w;
      end
      S_SCAN_CHK: begin
        map_wdata = pick.cur_word & ~(MAP_MSB >> clr_bit);
        if (pick.found) begin
          map_we[phase] = 1'b1;
          pos_we        = gslot_ok;
        end
      end
      S_FRAME: begin
        map_we[phase] = 1'b1;
      end
      S_EMIT: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      phase     <= '0;
      failed    <= 1'b0;
      rover     <= '0;
      cache_en  <= 1'b1;
      base      <= BASE_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + CLR_W'(1);
      // configuration beat
      if (cfg_beat) begin
        unique case (cfg_index)
          REG_CACHE_EN: cache_en <= cfg_data[0];
          REG_BASE:     base     <= cfg_data;
          default:      base     <= base;
        endcase
      end
      // frame advance rotates maps and clears the failure flag
      if (in_beat && req_type) begin
        phase  <= phase + 2'd1;
        failed <= 1'b0;
      end
      if (state == S_SCAN_CHK) begin
        if (pick.found)            rover  <= scan_w;
        else if (w_next == rover)  failed <= 1'b1;
      end
      // output register
      if (state == S_EMIT && res_ok) out_valid <= 1'b1;
      else if (out_ready)            out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      lat_handle  <= cached_handle;
      lat_x       <= pos_x;
      lat_y       <= pos_y;
      lat_z       <= pos_z;
      lat_slot    <= hit_d[SLOT_AW-1:0];
      lat_word    <= hit_d[5 +: WORD_W];
      lat_word_ok <= (hit_d[16:5] < 12'(MAP_WORDS));
      lat_bit     <= hit_d[4:0];
      res_handle  <= 16'd0;
      if (req_type) begin
        scan_w     <= '0;
        res_status <= ST_FRAME;
      end else begin
        scan_w     <= rover;
        res_status <= ST_EXHAUST;
      end
    end
    if (state == S_LOOK_CMP) begin
      scan_w <= rover;
      if (pos_match) begin
        res_handle <= lat_handle;
        res_status <= ST_HIT;
      end
    end
    if (state == S_SCAN_CHK) begin
      if (pick.found) begin
        res_handle <= grant_handle;
        res_status <= ST_ALLOC;
      end else begin
        scan_w <= w_next;
      end
    end
    if (state == S_FRAME) scan_w <= w_next;
    if (state == S_EMIT && res_ok) begin
      handle_out <= res_handle;
      status     <= res_status;
    end
  end

  // a new result only comes out of the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("out_valid rose outside emit");

  // an allocation never follows a sticky failure
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_status == ST_ALLOC) |-> !failed)
    else $error("allocation granted while pool failed");

  // frame beat clears the failure flag and moves the phase
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && req_type) |=> (!failed && phase == $past(phase) + 2'd1))
    else $error("frame advance did not update phase or failure flag");

  // outside the clearing pass at most one map is written at a time
  assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> $onehot0(map_we))
    else $error("more than one map written");

  // the rover stays inside the map
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK && pick.found) |=> (rover < WORD_W'(MAP_WORDS - 1) ||
      rover == WORD_W'(MAP_WORDS - 1)))
    else $error("rover beyond map");

endmodule

FILE: tb/sv/frame_aged_slot_allocator_test.sv
// frame_aged_slot_allocator_test: self-checking bench for the frame aged slot allocator
// drives requests and register writes, predicts every grant and checks it in order
// depends on fasa_pkg and frame_aged_slot_allocator
`timescale 1ns / 1ps

module frame_aged_slot_allocator_test;
  import fasa_pkg::*;

  localparam int SLOTS        = DEF_SLOTS;
  localparam int MAP_WORDS    = DEF_MAP_WORDS;
  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_FRAME  = 1'b1;
  localparam logic [15:0] BASE_MAX = 16'd64511;
  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 2 * MAP_WORDS + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int LIVE_DEPTH   = 64;

  typedef struct packed {
    logic [15:0] handle;
    status_t     status;
  } grant_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } held_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [15:0] cached_handle = '0;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] handle_out;
  status_t     status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // own copy of the pool state
  logic [31:0] map_word [4*MAP_WORDS];
  logic [31:0] kept_x [SLOTS];
  logic [31:0] kept_y [SLOTS];
  logic [31:0] kept_z [SLOTS];
  logic [4:0]  rover = '0;
  logic [1:0]  frame_phase = '0;
  bit          pool_dry = 1'b0;
  logic        pool_cache_en = 1'b1;
  logic [15:0] pool_base = BASE_RESET;

  grant_t     grants_due [$];
  held_slot_t live_handles [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_request = 0;
  int  stall_left = 0;
  bit  in_raised = 1'b0;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  reused_cnt = 0;
  int  granted_cnt = 0;
  int  refused_cnt = 0;
  int  frame_cnt = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;

  frame_aged_slot_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .cached_handle (cached_handle),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .handle_out    (handle_out),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // grant for one request, updates the pool copy
  function automatic grant_t serve_request(input logic req, input logic [15:0] h,
                                           input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
    grant_t      g;
    logic [1:0]  cur_m;
    logic [1:0]  prev_m;
    logic [1:0]  pprev_m;
    logic [31:0] slot;
    logic [31:0] word;
    int          w;
    int          start;
    int          lz;
    bit          found;
    g.handle = '0;
    g.status = ST_FRAME;
    // frame step: rotate and refill the new current map
    if (req == REQ_FRAME) begin
      frame_phase = frame_phase + 2'd1;
      pool_dry = 1'b0;
      for (int i = 0; i < MAP_WORDS; i++)
        map_word[int'(frame_phase) * MAP_WORDS + i] = '1;
      return g;
    end
    cur_m = frame_phase;
    prev_m = frame_phase - 2'd1;
    pprev_m = frame_phase - 2'd2;
    // cached handle with unchanged position
    if (h != 16'h0000 && pool_cache_en) begin
      slot = h - 1 - pool_base;
      if (slot < SLOTS && kept_x[slot] == x && kept_y[slot] == y && kept_z[slot] == z) begin
        if ((slot >> 5) < MAP_WORDS)
          map_word[int'(cur_m) * MAP_WORDS + int'(slot >> 5)][31 - slot[4:0]] = 1'b0;
        g.handle = h;
        g.status = ST_HIT;
        return g;
      end
    end
    g.status = ST_EXHAUST;
    if (pool_dry)
      return g;
    // scan from the rover for a word free in all three ages
    start = int'(rover) % MAP_WORDS;
    found = 1'b0;
    w = start;
    lz = 32;
    for (int k = 0; k < MAP_WORDS && !found; k++) begin
      w = (start + k) % MAP_WORDS;
      word = map_word[int'(cur_m) * MAP_WORDS + w] & map_word[int'(prev_m) * MAP_WORDS + w]
             & map_word[int'(pprev_m) * MAP_WORDS + w];
      if (word != 32'h0) begin
        found = 1'b1;
        for (int b = 0; b < 32; b++)
          if (word[b]) lz = 31 - b;
      end
    end
    if (!found) begin
      pool_dry = 1'b1;
      return g;
    end
    rover = 5'(w);
    map_word[int'(cur_m) * MAP_WORDS + w][31 - lz] = 1'b0;
    slot = lz + 32 * w;
    if (slot < SLOTS) begin
      kept_x[slot] = x;
      kept_y[slot] = y;
      kept_z[slot] = z;
    end
    g.handle = 16'(slot + pool_base + 1);
    g.status = ST_ALLOC;
    return g;
  endfunction

  // position word, biased toward the special patterns
  function automatic logic [31:0] pick_coord();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return POS_RESET;
    return $urandom;
  endfunction

  task automatic set_profile(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic drop_valid();
    if (in_raised) begin
      in_valid <= 1'b0;
      in_raised = 1'b0;
    end
  endtask

  // one request beat, predicted at acceptance
  task automatic send_item(input logic req, input logic [15:0] h, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    int         gap;
    grant_t     g;
    held_slot_t s;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    cached_handle <= h;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    in_raised = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    g = serve_request(req, h, x, y, z);
    grants_due.push_back(g);
    items_sent++;
    if (g.status == ST_ALLOC) begin
      s = '{handle: g.handle, x: x, y: y, z: z};
      live_handles.push_back(s);
      if (live_handles.size() > LIVE_DEPTH) void'(live_handles.pop_front());
    end
  endtask

  // sender pause until every grant is back
  task automatic wait_drained();
    drop_valid();
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // both registers, back to back beats
  task automatic program_pool(input logic en, input logic [15:0] base);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CACHE_EN;
    cfg_data <= {15'd0, en};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pool_cache_en = en;
    cfg_index <= REG_BASE;
    cfg_data <= base;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pool_base = base;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // mostly well-formed reuse of granted handles, plus noise
  task automatic mixed_requests(input int count);
    int          pick;
    held_slot_t  s;
    logic [31:0] bitflip;
    repeat (count) begin
      pick = $urandom_range(99);
      s = '{handle: 16'h0000, x: POS_RESET, y: POS_RESET, z: POS_RESET};
      if (live_handles.size() != 0)
        s = live_handles[$urandom_range(live_handles.size() - 1)];
      bitflip = 32'h1 << $urandom_range(31);
      if (pick < 7) begin
        send_item(REQ_FRAME, 16'($urandom), $urandom, $urandom, $urandom);
      end else if (pick < 47) begin
        send_item(REQ_ALLOC, s.handle, s.x, s.y, s.z);
      end else if (pick < 57) begin
        // stale position, one bit off
        if (pick < 51) s.x ^= bitflip;
        else if (pick < 54) s.y ^= bitflip;
        else s.z ^= bitflip;
        send_item(REQ_ALLOC, s.handle, s.x, s.y, s.z);
      end else if (pick < 67) begin
        send_item(REQ_ALLOC, 16'($urandom), pick_coord(), pick_coord(), pick_coord());
      end else if (pick < 73) begin
        send_item(REQ_ALLOC, 16'(pool_base + 1 + $urandom_range(SLOTS - 1)),
                  POS_RESET, POS_RESET, POS_RESET);
      end else begin
        send_item(REQ_ALLOC, 16'h0000, pick_coord(), pick_coord(), pick_coord());
      end
    end
  endtask

  // hit, miss and handle range corners, cache off, base extremes
  task automatic test_cache_paths();
    held_slot_t t;
    program_pool(1'b1, BASE_RESET);
    send_item(REQ_ALLOC, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000);
    t = live_handles[live_handles.size() - 1];
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    send_item(REQ_ALLOC, t.handle, t.x ^ 32'h1, t.y, t.z);
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z ^ 32'h8000_0000);
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    // handle below base wraps and misses
    send_item(REQ_ALLOC, 16'd5, POS_RESET, POS_RESET, POS_RESET);
    send_item(REQ_ALLOC, 16'hFFFF, POS_RESET, POS_RESET, POS_RESET);
    // never written slot still holds the reset pattern
    send_item(REQ_ALLOC, 16'(BASE_RESET + SLOTS), POS_RESET, POS_RESET, POS_RESET);
    send_item(REQ_ALLOC, 16'(BASE_RESET + SLOTS + 1), POS_RESET, POS_RESET, POS_RESET);
    // frame step ignores the other fields
    send_item(REQ_FRAME, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    send_item(REQ_FRAME, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_item(REQ_ALLOC, 16'h0000, POS_RESET, POS_RESET, POS_RESET);
    wait_drained();
    program_pool(1'b0, BASE_MAX);
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    send_item(REQ_ALLOC, 16'hFFFF, POS_RESET, POS_RESET, POS_RESET);
    send_item(REQ_ALLOC, 16'h0000, pick_coord(), pick_coord(), pick_coord());
    t = live_handles[live_handles.size() - 1];
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    wait_drained();
    program_pool(1'b1, 16'd0);
    send_item(REQ_ALLOC, 16'h0000, $urandom, $urandom, $urandom);
    t = live_handles[live_handles.size() - 1];
    send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    send_item(REQ_ALLOC, 16'd1, POS_RESET, POS_RESET, POS_RESET);
    send_item(REQ_ALLOC, 16'hFFFF, POS_RESET, POS_RESET, POS_RESET);
  endtask

  // fill the whole pool, sticky failure, recovery over three frames
  task automatic test_pool_exhaustion();
    held_slot_t t;
    wait_drained();
    program_pool(1'b1, 16'($urandom_range(BASE_MAX)));
    repeat (SLOTS + 8)
      send_item(REQ_ALLOC, 16'h0000, $urandom, $urandom, $urandom);
    // hits still granted while the pool is dry
    repeat (4) begin
      t = live_handles[$urandom_range(live_handles.size() - 1)];
      send_item(REQ_ALLOC, t.handle, t.x, t.y, t.z);
    end
    send_item(REQ_ALLOC, t.handle, ~t.x, t.y, t.z);
    repeat (3) begin
      send_item(REQ_FRAME, 16'($urandom), $urandom, $urandom, $urandom);
      repeat (3) send_item(REQ_ALLOC, 16'h0000, $urandom, $urandom, $urandom);
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_output_backpressure();
    wait_drained();
    stall_request = HOLD_CYCLES;
    repeat (8) send_item(REQ_ALLOC, 16'h0000, pick_coord(), pick_coord(), pick_coord());
    wait_drained();
    mixed_requests(12);
  endtask

  task automatic test_config_sweep();
    wait_drained();
    program_pool(1'b1, 16'($urandom_range(BASE_MAX)));
    mixed_requests(150);
    wait_drained();
    program_pool(1'b0, 16'($urandom_range(BASE_MAX)));
    mixed_requests(60);
    wait_drained();
    program_pool(1'b1, 16'd0);
    mixed_requests(150);
  endtask

  task automatic test_random_traffic();
    wait_drained();
    program_pool(1'b1, BASE_MAX);
    mixed_requests(150);
    wait_drained();
    program_pool(1'b1, 16'($urandom_range(BASE_MAX)));
    mixed_requests(250);
  endtask

  task automatic flag_mismatch(input string what, input grant_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected handle %h status %s, got handle %h status %s", $realtime,
               what, want.handle, want.status.name(), handle_out, status.name());
  endtask

  // receiver: random stalls, long hold on request
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat with the oldest grant due
  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      case (status)
        ST_HIT:     reused_cnt++;
        ST_ALLOC:   granted_cnt++;
        ST_EXHAUST: refused_cnt++;
        default:    frame_cnt++;
      endcase
      if (grants_due.size() == 0) begin
        want = '0;
        flag_mismatch("unexpected result", want);
      end else begin
        want = grants_due.pop_front();
        if (handle_out !== want.handle || status !== want.status)
          flag_mismatch("result mismatch", want);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4 * MAP_WORDS; i++) map_word[i] = '1;
    for (int i = 0; i < SLOTS; i++) begin
      kept_x[i] = POS_RESET;
      kept_y[i] = POS_RESET;
      kept_z[i] = POS_RESET;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_profile(20, 84);
    test_cache_paths();
    test_pool_exhaustion();
    set_profile(84, 20);
    test_output_backpressure();
    test_config_sweep();
    set_profile(0, 0);
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d requests and %0d register writes over cache on/off and base 0 to max",
             items_sent, cfg_writes);
    $display("results: %0d reused, %0d granted, %0d refused, %0d frame steps, %0d mismatches",
             reused_cnt, granted_cnt, refused_cnt, frame_cnt, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
